>>> src/sgf_pkg.sv
// ----------------------------------------------------------------------------
// sgf_pkg
// Shared types, widths and register codes of the symmetric smoothing filter.
// ----------------------------------------------------------------------------
package sgf_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 16;
	localparam int PAIR_W       = SAMPLE_W + 1;
	localparam int PROD_W       = PAIR_W + COEF_W + 1;
	localparam int FRAC_BITS    = 15;
	localparam int ROUND_BIAS   = 1 << (FRAC_BITS - 1);
	localparam int SMP_MAX      = 32767;
	localparam int SMP_MIN      = -32768;
	localparam int MAX_HALF_DEF = 3;
	localparam int NUM_COEF     = 4;
	localparam int HALF_REG_W   = 2;
	localparam int CFG_IDX_W    = 3;

	typedef logic signed [SAMPLE_W-1:0] smp_t;
	typedef logic signed [PAIR_W-1:0]   pair_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic [COEF_W-1:0]          coef_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	// register indexes of the configuration port
	localparam cfg_idx_t REG_HALF_WIDTH  = 3'd0;
	localparam cfg_idx_t REG_COEF_CENTER = 3'd1;
	localparam cfg_idx_t REG_COEF_DIST1  = 3'd2;
	localparam cfg_idx_t REG_COEF_DIST2  = 3'd3;
	localparam cfg_idx_t REG_COEF_DIST3  = 3'd4;

	localparam logic [HALF_REG_W-1:0] HALF_WIDTH_RST  = 2'd3;
	localparam coef_t                 COEF_CENTER_RST = 16'd32768;

	typedef struct packed {
		smp_t sample_in;
		logic seq_end;
	} sgf_in_t;

	typedef struct packed {
		smp_t sample_out;
		logic out_last;
	} sgf_out_t;

	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
	} sgf_pipe_ctl_t;

endpackage

>>> src/sgf_tap_cell.sv
// ----------------------------------------------------------------------------
// sgf_tap_cell
// One sample of the delay line; takes its neighbour's sample on each item.
// ----------------------------------------------------------------------------
module sgf_tap_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  sgf_pkg::smp_t d,
	output sgf_pkg::smp_t q
);
	import sgf_pkg::*;

	smp_t smp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q <= '0;
		end else if (shift) begin
			smp_q <= d;
		end
	end

	assign q = smp_q;

endmodule

>>> src/sgf_burst_cell.sv
// ----------------------------------------------------------------------------
// sgf_burst_cell
// One slot of the result burst; loaded in parallel, drained towards slot zero.
// ----------------------------------------------------------------------------
module sgf_burst_cell (
	input  logic          clk,
	input  logic          load,
	input  logic          shift,
	input  sgf_pkg::smp_t load_d,
	input  sgf_pkg::smp_t next_d,
	output sgf_pkg::smp_t q
);
	import sgf_pkg::*;

	smp_t slot_q;

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= load_d;
		end else if (shift) begin
			slot_q <= next_d;
		end
	end

	assign q = slot_q;

endmodule

>>> src/sgf_mac.sv
// ----------------------------------------------------------------------------
// sgf_mac
// Weight multiply, sum, round and saturate for the symmetric taps.
// ----------------------------------------------------------------------------
module sgf_mac #(
	parameter int MAX_HALF = sgf_pkg::MAX_HALF_DEF
) (
	input  logic                  clk,
	input  sgf_pkg::sgf_pipe_ctl_t ctl,
	input  sgf_pkg::smp_t         center_s1,
	input  sgf_pkg::pair_t        pair_s1 [MAX_HALF],
	input  sgf_pkg::coef_t        coef [sgf_pkg::NUM_COEF],
	output sgf_pkg::smp_t         filt
);
	import sgf_pkg::*;

	localparam int NumTerm = MAX_HALF + 1;
	localparam int AccW    = PROD_W + $clog2(NumTerm);

	prod_t                 prod_s2 [NumTerm];
	logic signed [AccW-1:0] sum;
	logic signed [AccW-1:0] acc_s3;
	logic signed [AccW-1:0] rnd;
	logic signed [AccW-1:0] quo;

	// one multiplier per distance, operands widened to signed 17 bits
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			prod_s2[0] <= $signed({1'b0, coef[0]}) * PAIR_W'(center_s1);
			for (int k = 1; k < NumTerm; k++) begin
				prod_s2[k] <= $signed({1'b0, coef[k]}) * pair_s1[k-1];
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < NumTerm; k++) begin
			sum = sum + AccW'(prod_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			acc_s3 <= sum;
		end
	end

	// halves round towards plus infinity
	assign rnd = acc_s3 + AccW'(ROUND_BIAS);
	assign quo = rnd >>> FRAC_BITS;

	always_comb begin
		if (quo > AccW'(SMP_MAX)) begin
			filt = smp_t'(SMP_MAX);
		end else if (quo < AccW'(SMP_MIN)) begin
			filt = smp_t'(SMP_MIN);
		end else begin
			filt = quo[SAMPLE_W-1:0];
		end
	end

endmodule

>>> src/symmetric_gaussian_fir_filter_unit.sv
// ----------------------------------------------------------------------------
// symmetric_gaussian_fir_filter_unit
// Symmetric FIR smoothing filter of up to 2*MAX_HALF+1 taps on 16-bit samples.
// ----------------------------------------------------------------------------
// Samples enter on smp_valid/smp_ready, one item per cycle; seq_end marks the
// last sample of a sequence. Results leave on res_valid/res_ready in sequence
// order; out_last marks the final result of the sequence.
// Weights and half width are written on cfg_valid/cfg_ready (always ready);
// the user must write only while the filter holds no items (not enforced).
// Stages s1, s2, s3 and the burst slots lie between an item and its result;
// an inner sample is completed by the sample half_width positions later.
// Throughput: one item per cycle. The item marked seq_end yields up to
// MAX_HALF+1 results, leaving burst slots one per cycle with res_ready high;
// the input is held back only while that burst cannot be refilled.
// The path is a delay line of tap cells, a pre-add stage, a multiply stage,
// a sum stage and the burst slots, all stalling together when res_ready
// stays low, so nothing is lost or repeated.
// Reset clears the delay line, the sample count, all stage valids and sets
// half width 3, centre weight 1.0 and the other weights 0.
// ----------------------------------------------------------------------------
module symmetric_gaussian_fir_filter_unit #(
	parameter int MAX_HALF = sgf_pkg::MAX_HALF_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              smp_valid,
	output logic              smp_ready,
	input  sgf_pkg::sgf_in_t  smp_data,
	output logic              res_valid,
	input  logic              res_ready,
	output sgf_pkg::sgf_out_t res_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  sgf_pkg::cfg_idx_t cfg_index,
	input  sgf_pkg::coef_t    cfg_data
);
	import sgf_pkg::*;

	localparam int WinLen = 2 * MAX_HALF + 1;
	localparam int CntW   = $clog2(WinLen + 1);
	localparam int IdxW   = $clog2(WinLen);
	localparam int HalfW  = $clog2(MAX_HALF + 1);
	localparam int NumRes = MAX_HALF + 1;
	localparam int NumW   = $clog2(NumRes + 1);

	// configuration
	logic [HALF_REG_W-1:0] half_width_q;
	coef_t                 coef_q [NUM_COEF];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RST;
			coef_q[0]    <= COEF_CENTER_RST;
			for (int i = 1; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HALF_WIDTH:  half_width_q <= cfg_data[HALF_REG_W-1:0];
				REG_COEF_CENTER: coef_q[0] <= cfg_data;
				REG_COEF_DIST1:  coef_q[1] <= cfg_data;
				REG_COEF_DIST2:  coef_q[2] <= cfg_data;
				REG_COEF_DIST3:  coef_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [HalfW-1:0] h;
	assign h = (half_width_q > HALF_REG_W'(MAX_HALF)) ? HalfW'(MAX_HALF)
	                                                  : half_width_q[HalfW-1:0];

	// handshake and stall chain
	logic smp_acc, res_acc;
	logic en1, en2, en3, burst_free, burst_load;
	logic v_s1, v_s2, v_s3;
	logic [NumW-1:0] rem_q;
	logic            last_q;

	assign burst_free = (rem_q == '0) || (res_ready && rem_q == NumW'(1));
	assign en3        = !v_s3 || burst_free;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign smp_ready  = en1;
	assign smp_acc    = smp_valid && smp_ready;
	assign res_valid  = rem_q != '0;
	assign res_acc    = res_valid && res_ready;
	assign burst_load = v_s3 && burst_free;

	// delay line: nw is the window after this item shifts in
	smp_t tap_q [WinLen-1];
	smp_t nw    [WinLen];

	assign nw[0] = smp_data.sample_in;

	for (genvar gi = 0; gi < WinLen - 1; gi++) begin : g_tap
		sgf_tap_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (smp_acc),
			.d      (nw[gi]),
			.q      (tap_q[gi])
		);
		assign nw[gi+1] = tap_q[gi];
	end

	// samples seen in the current sequence, saturating at the window length
	logic [CntW-1:0] cnt_q, cnt_nx, h_c, h2_c;

	assign cnt_nx = (cnt_q < CntW'(WinLen)) ? cnt_q + 1'b1 : cnt_q;
	assign h_c    = CntW'(h);
	assign h2_c   = CntW'({h, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (smp_acc) begin
			cnt_q <= smp_data.seq_end ? '0 : cnt_nx;
		end
	end

	// results of this item: slot j holds nw[base-j], slot zero may be filtered
	logic             plan_filt;
	logic [NumW-1:0]  plan_n;
	logic [HalfW-1:0] plan_base;
	smp_t             plan_raw [NumRes];
	smp_t             center;
	pair_t            pair [MAX_HALF];

	always_comb begin
		plan_filt = 1'b0;
		plan_n    = '0;
		plan_base = '0;
		if (h == '0) begin
			plan_n = NumW'(1);
		end else if (!smp_data.seq_end) begin
			if (cnt_nx > h2_c) begin
				plan_filt = 1'b1;
				plan_n    = NumW'(1);
				plan_base = h;
			end else if (cnt_nx > h_c) begin
				plan_n    = NumW'(1);
				plan_base = h;
			end
		end else if (cnt_nx <= h_c) begin
			// short sequence: everything passes through now
			plan_n    = NumW'(cnt_nx);
			plan_base = HalfW'(cnt_nx - 1'b1);
		end else begin
			plan_filt = cnt_nx > h2_c;
			plan_n    = NumW'(h) + 1'b1;
			plan_base = h;
		end
	end

	always_comb begin
		for (int j = 0; j < NumRes; j++) begin
			plan_raw[j] = (j <= int'(plan_base)) ? nw[IdxW'(int'(plan_base) - j)] : '0;
		end
		center = nw[IdxW'(h)];
		for (int k = 1; k <= MAX_HALF; k++) begin
			pair[k-1] = (k <= int'(h))
				? PAIR_W'(nw[IdxW'(int'(h) - k)]) + PAIR_W'(nw[IdxW'(int'(h) + k)])
				: '0;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= smp_acc && (plan_n != '0);
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s1 ? v_s2 : v_s2;
		end
	end

	// stage payloads
	smp_t            center_s1;
	pair_t           pair_s1 [MAX_HALF];
	logic            filt_s1, filt_s2, filt_s3;
	logic            last_s1, last_s2, last_s3;
	logic [NumW-1:0] n_s1, n_s2, n_s3;
	smp_t            raw_s1 [NumRes];
	smp_t            raw_s2 [NumRes];
	smp_t            raw_s3 [NumRes];

	always_ff @(posedge clk) begin
		if (en1 && smp_acc) begin
			center_s1 <= center;
			pair_s1   <= pair;
			filt_s1   <= plan_filt;
			last_s1   <= smp_data.seq_end;
			n_s1      <= plan_n;
			raw_s1    <= plan_raw;
		end
		if (en2) begin
			filt_s2 <= filt_s1;
			last_s2 <= last_s1;
			n_s2    <= n_s1;
			raw_s2  <= raw_s1;
		end
		if (en3) begin
			filt_s3 <= filt_s2;
			last_s3 <= last_s2;
			n_s3    <= n_s2;
			raw_s3  <= raw_s2;
		end
	end

	sgf_pipe_ctl_t mac_ctl;
	smp_t          filt_val;

	assign mac_ctl.adv_s2 = en2;
	assign mac_ctl.adv_s3 = en3;

	sgf_mac #(
		.MAX_HALF (MAX_HALF)
	) u_mac (
		.clk       (clk),
		.ctl       (mac_ctl),
		.center_s1 (center_s1),
		.pair_s1   (pair_s1),
		.coef      (coef_q),
		.filt      (filt_val)
	);

	// output burst
	smp_t slot_q [NumRes];

	for (genvar gj = 0; gj < NumRes; gj++) begin : g_slot
		smp_t load_d, next_d;
		if (gj == 0) begin : g_head
			assign load_d = filt_s3 ? filt_val : raw_s3[gj];
		end else begin : g_body
			assign load_d = raw_s3[gj];
		end
		if (gj < NumRes - 1) begin : g_mid
			assign next_d = slot_q[gj+1];
		end else begin : g_tail
			assign next_d = '0;
		end
		sgf_burst_cell u_cell (
			.clk    (clk),
			.load   (burst_load),
			.shift  (res_acc && !burst_load),
			.load_d (load_d),
			.next_d (next_d),
			.q      (slot_q[gj])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			last_q <= 1'b0;
		end else if (burst_load) begin
			rem_q  <= n_s3;
			last_q <= last_s3;
		end else if (res_acc) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	assign res_data.sample_out = slot_q[0];
	assign res_data.out_last   = last_q && (rem_q == NumW'(1));

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(WinLen))
		else $error("sample count beyond window length");

	a_seq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc && smp_data.seq_end |=> cnt_q == '0)
		else $error("count not cleared after end of sequence");

	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (n_s3 != '0) && (n_s3 <= NumW'(NumRes)))
		else $error("burst of illegal length in last stage");

	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s3 || burst_free) |-> smp_ready)
		else $error("input held back with a free output side");

	a_burst_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= NumW'(NumRes))
		else $error("burst count beyond slot count");

endmodule
